// ===== hdl/cmf_pkg.sv =====
// Package for the cross median filter: shared widths, state codes and the
// sorter control bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cmf_pkg;

  localparam int DATA_W = 32;
  localparam int SIDE_W = 4;
  localparam int CNT_W  = 7;
  localparam int NCNT_W = 3;
  localparam logic [SIDE_W-1:0] SIDE_RST = 4'd8;
  localparam logic [SIDE_W-1:0] SIDE_MIN = 4'd2;

  // Register indexes of the configuration port.
  localparam logic REG_SIDE = 1'b0;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_FLUSH = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    PH_CORNER = 3'b001,
    PH_EDGE   = 3'b010,
    PH_INNER  = 3'b100
  } phase_t;

  typedef struct packed {
    logic              clr;
    logic              ins;
    logic [NCNT_W-1:0] cnt;
  } sort_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/cmf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cmf_sort.sv =====
// Insertion sorter that gathers up to five values and gives their median.
// Depends on cmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmf_sort (
  input  wire logic                       clk,
  input  wire cmf_pkg::sort_ctrl_t        ctrl,
  input  wire logic [cmf_pkg::DATA_W-1:0] din,
  output logic      [cmf_pkg::DATA_W-1:0] med
);
  import cmf_pkg::*;

  logic [DATA_W-1:0] srt_r [5];
  logic [DATA_W-1:0] srt_nxt [5];
  logic [DATA_W:0]   mid_sum;

  // Empty slots hold all ones, so a new value always lands in sorted order.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if (ctrl.clr) begin
        srt_nxt[i] = '1;
      end else if (!ctrl.ins || srt_r[i] <= din) begin
        srt_nxt[i] = srt_r[i];
      end else if (i == 0 || srt_r[(i == 0) ? 0 : i-1] <= din) begin
        srt_nxt[i] = din;
      end else begin
        srt_nxt[i] = srt_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_comb begin
    mid_sum = {1'b0, srt_r[1]} + {1'b0, srt_r[2]};
    priority case (ctrl.cnt)
      3'd5:    med = srt_r[2];
      3'd4:    med = mid_sum[DATA_W:1];
      default: med = srt_r[1];
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) begin
      srt_r[i] <= srt_nxt[i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/matrix_cross_median_filter.sv =====
// Five-point cross median filter over a square matrix held in one RAM.
// Depends on cmf_pkg, cmf_ram and cmf_sort.
`timescale 1ns / 1ps
`default_nettype none
// The block takes a square matrix of side_length (2 to MAX_SIDE) entries a
// side, one entry per transaction in row-major order, at one transaction per
// cycle. The transaction that completes the matrix starts the in-place
// filter, during which no input is accepted. Each entry is filtered by
// reading itself and its neighbours through the single read port of the
// matrix RAM, one read a cycle, then writing the median back after a flush
// state: a corner reads two neighbours, an edge entry three and an interior
// entry four. The filtered matrix then streams out at one transaction per
// cycle while the output is not stalled, and loading of the next matrix
// resumes once the last read has been issued. No clearing pass follows
// reset.
module matrix_cross_median_filter #(
  parameter int MAX_SIDE = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [cmf_pkg::DATA_W-1:0] in_tdata,   // [31:0] element_value
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [cmf_pkg::DATA_W-1:0] out_tdata,  // [31:0] filtered_value
  output logic                            out_tlast,  // last_element
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import cmf_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_SIDE);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [SIDE_W-1:0] side_r, side_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIDE_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0]  tot_r, tot_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic [PW-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic [4:0]        used_r, used_nxt;
  logic              f_pend_r, f_pend_nxt;
  logic              e_pend_r, e_pend_nxt;
  logic              e_pl_r, e_pl_nxt;
  logic [AW-1:0]     e_addr_r, e_addr_nxt;
  logic              out_v_r, out_v_nxt, sk_v_r, sk_v_nxt;
  logic [DATA_W-1:0] out_d_r, out_d_nxt, sk_d_r, sk_d_nxt;
  logic              out_l_r, out_l_nxt, sk_l_r, sk_l_nxt;

  logic              cfg_wr, in_acc, pop, can_issue, e_last;
  logic [1:0]        occ;
  logic [SIDE_W-1:0] n_eff;
  logic [CNT_W-1:0]  tot_w, cnt_inc;
  logic [PW-1:0]     nm1, row, col;
  logic [AW-1:0]     base, pick_addr;
  logic [4:0]        present, rem, pick;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_wa, ram_ra;
  logic [DATA_W-1:0] ram_wd, ram_rd, med;
  sort_ctrl_t        sctl;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIDE);
  assign prdata = (paddr[2] == REG_SIDE) ? {{(32-SIDE_W){1'b0}}, side_r} : '0;
  assign side_nxt = cfg_wr ? pwdata[SIDE_W-1:0] : side_r;

  always_comb begin
    if (side_r < SIDE_MIN) begin
      n_eff = SIDE_MIN;
    end else if (side_r > SIDE_W'(MAX_SIDE)) begin
      n_eff = SIDE_W'(MAX_SIDE);
    end else begin
      n_eff = side_r;
    end
  end

  assign tot_w   = CNT_W'(n_eff) * CNT_W'(n_eff);
  assign cnt_inc = cnt_r + 1'b1;
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;

  // Position of the entry being filtered.
  assign nm1 = PW'(n_r - SIDE_W'(1));

  always_comb begin
    unique case (phase_r)
      PH_CORNER: begin
        row = sub_r[1] ? nm1 : '0;
        col = sub_r[0] ? nm1 : '0;
      end
      PH_EDGE: begin
        unique case (sub_r)
          2'd0: begin row = '0;  col = a_r; end
          2'd1: begin row = nm1; col = a_r; end
          2'd2: begin row = a_r; col = '0;  end
          default: begin row = a_r; col = nm1; end
        endcase
      end
      PH_INNER: begin
        row = a_r;
        col = b_r;
      end
      default: begin
        row = '0;
        col = '0;
      end
    endcase
  end

  assign base    = AW'(row) * AW'(n_r) + AW'(col);
  // Slots: self, up, down, left, right.
  assign present = {col != nm1, col != '0, row != nm1, row != '0, 1'b1};
  assign rem     = present & ~used_r;
  assign pick    = rem & (~rem + 5'd1);

  always_comb begin
    priority if (pick[0]) begin
      pick_addr = base;
    end else if (pick[1]) begin
      pick_addr = base - AW'(n_r);
    end else if (pick[2]) begin
      pick_addr = base + AW'(n_r);
    end else if (pick[3]) begin
      pick_addr = base - AW'(1);
    end else begin
      pick_addr = base + AW'(1);
    end
  end

  // Output register and skid stage.
  assign pop       = out_v_r && out_tready;
  assign occ       = {1'b0, out_v_r} + {1'b0, sk_v_r} + {1'b0, e_pend_r};
  assign can_issue = (occ - {1'b0, pop}) < 2'd2;
  assign e_last    = (CNT_W'(e_addr_r) == tot_r - CNT_W'(1));

  always_comb begin
    out_v_nxt = out_v_r && !pop;
    out_d_nxt = out_d_r;
    out_l_nxt = out_l_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    sk_l_nxt  = sk_l_r;
    if (sk_v_nxt && !out_v_nxt) begin
      out_v_nxt = 1'b1;
      out_d_nxt = sk_d_r;
      out_l_nxt = sk_l_r;
      sk_v_nxt  = 1'b0;
    end
    if (e_pend_r) begin
      if (!out_v_nxt) begin
        out_v_nxt = 1'b1;
        out_d_nxt = ram_rd;
        out_l_nxt = e_pl_r;
      end else begin
        sk_v_nxt = 1'b1;
        sk_d_nxt = ram_rd;
        sk_l_nxt = e_pl_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    tot_nxt    = tot_r;
    sub_nxt    = sub_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    used_nxt   = used_r;
    e_addr_nxt = e_addr_r;
    e_pl_nxt   = e_pl_r;
    f_pend_nxt = 1'b0;
    e_pend_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_wa     = cnt_r[AW-1:0];
    ram_wd     = in_tdata;
    ram_re     = 1'b0;
    ram_ra     = pick_addr;
    sctl.clr   = 1'b0;
    sctl.ins   = f_pend_r;
    sctl.cnt   = NCNT_W'($countones(present));
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          ram_we = 1'b1;
          if (cnt_inc >= tot_w) begin
            cnt_nxt   = '0;
            n_nxt     = n_eff;
            tot_nxt   = tot_w;
            phase_nxt = PH_CORNER;
            sub_nxt   = '0;
            used_nxt  = '0;
            sctl.clr  = 1'b1;
            state_nxt = ST_READ;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        f_pend_nxt = 1'b1;
        used_nxt   = used_r | pick;
        if ((rem & ~pick) == '0) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_wa    = base;
        ram_wd    = med;
        sctl.clr  = 1'b1;
        used_nxt  = '0;
        state_nxt = ST_READ;
        unique case (phase_r)
          PH_CORNER: begin
            sub_nxt = sub_r + 2'd1;
            if (sub_r == 2'd3) begin
              if (nm1 > PW'(1)) begin
                phase_nxt = PH_EDGE;
                a_nxt     = PW'(1);
              end else begin
                state_nxt = ST_EMIT;
              end
            end
          end
          PH_EDGE: begin
            sub_nxt = sub_r + 2'd1;
            if (sub_r == 2'd3) begin
              if (a_r == nm1 - PW'(1)) begin
                phase_nxt = PH_INNER;
                a_nxt     = PW'(1);
                b_nxt     = PW'(1);
              end else begin
                a_nxt = a_r + PW'(1);
              end
            end
          end
          default: begin
            if (b_r == nm1 - PW'(1)) begin
              b_nxt = PW'(1);
              if (a_r == nm1 - PW'(1)) begin
                state_nxt = ST_EMIT;
              end else begin
                a_nxt = a_r + PW'(1);
              end
            end else begin
              b_nxt = b_r + PW'(1);
            end
          end
        endcase
        if (state_nxt == ST_EMIT) begin
          e_addr_nxt = '0;
        end
      end
      ST_EMIT: begin
        ram_ra = e_addr_r;
        if (can_issue) begin
          ram_re     = 1'b1;
          e_pend_nxt = 1'b1;
          e_pl_nxt   = e_last;
          if (e_last) begin
            state_nxt = ST_LOAD;
          end else begin
            e_addr_nxt = e_addr_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  cmf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  cmf_sort u_sort (
    .clk  (clk),
    .ctrl (sctl),
    .din  (ram_rd),
    .med  (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      side_r   <= SIDE_RST;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      sk_v_r   <= 1'b0;
      e_pend_r <= 1'b0;
      f_pend_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      side_r   <= side_nxt;
      cnt_r    <= cnt_nxt;
      out_v_r  <= out_v_nxt;
      sk_v_r   <= sk_v_nxt;
      e_pend_r <= e_pend_nxt;
      f_pend_r <= f_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    n_r      <= n_nxt;
    tot_r    <= tot_nxt;
    sub_r    <= sub_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    used_r   <= used_nxt;
    e_addr_r <= e_addr_nxt;
    e_pl_r   <= e_pl_nxt;
    out_d_r  <= out_d_nxt;
    out_l_r  <= out_l_nxt;
    sk_d_r   <= sk_d_nxt;
    sk_l_r   <= sk_l_nxt;
  end

  // The store is never written and read in the same cycle.
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("matrix store written and read in one cycle");

  // The skid stage only fills behind a full output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n) sk_v_r |-> out_v_r)
    else $error("skid stage holds data while output register is empty");

  // Issued emit reads never exceed the two output slots.
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({out_v_r, sk_v_r, e_pend_r}) <= 2)
    else $error("output buffer overcommitted");

  // Loading never overlaps a filter read still in flight.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !f_pend_r)
    else $error("input accepted during filter reads");

endmodule
`default_nettype wire
